// ===== sv/lfmc_pkg.sv =====
// Package for the line follower mode controller.
// Holds the mode type, the configuration register indexes and the reset values.
// No dependencies.
package lfmc_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_LEFT_WAIT = 2'd1,
        MODE_LEFT_SPIN = 2'd2,
        MODE_RIGHT     = 2'd3
    } t_mode;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned RUN_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSSING_RUN_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_RUN_LEN     = 2'd2;

    localparam logic [SAMPLE_W-1:0] BLACK_THRESHOLD_RST  = 8'd128;
    localparam logic [RUN_W-1:0]    CROSSING_RUN_LEN_RST = 8'd4;
    localparam logic [RUN_W-1:0]    SIDE_RUN_LEN_RST     = 8'd8;

    localparam logic [RUN_W-1:0] RUN_MAX = '1;

endpackage

// ===== sv/line_follower_mode_controller.sv =====
// Line follower mode controller: sample classification, mode state machine,
// run counters and motor direction output register.
// Depends on lfmc_pkg.

// One left/right sample pair is taken per beat and yields exactly one result beat
// in the next cycle. The block accepts a new pair in every cycle; the single output
// register sets the rate at one pair per clock, and input is held off only while
// that register holds a result the sink has not yet taken. Each sample is black
// when it is at or above black_threshold. The mode register moves first, from the
// run counters and both-white flag of earlier beats and the current pattern; the
// motor directions then follow from the current pattern and the new mode; last the
// saturating run counters update. Configuration writes take effect on the next beat
// and must be made while no beat is in flight.
module line_follower_mode_controller
    import lfmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] left_sample, [15:8] right_sample
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] left_motor_reverse, [1] right_motor_reverse,
                                        // [3:2] mode, [7:4] zero
);

    logic [SAMPLE_W-1:0] r_black_threshold;
    logic [RUN_W-1:0]    r_crossing_run_len;
    logic [RUN_W-1:0]    r_side_run_len;

    t_mode            r_mode, n_mode;
    logic [RUN_W-1:0] r_both_black_run, n_both_black_run;
    logic [RUN_W-1:0] r_left_black_run, n_left_black_run;
    logic             r_last_both_white;

    logic       r_out_valid;
    logic       r_left_rev, n_left_rev;
    logic       r_right_rev, n_right_rev;
    t_mode      r_out_mode;

    logic [SAMPLE_W-1:0] left_sample, right_sample;
    logic left_black, right_black;
    logic both_black, both_white, left_only;
    logic accept;

    assign left_sample  = s_axis_tdata[7:0];
    assign right_sample = s_axis_tdata[15:8];

    assign left_black  = left_sample >= r_black_threshold;
    assign right_black = right_sample >= r_black_threshold;
    assign both_black  = left_black && right_black;
    assign both_white  = !left_black && !right_black;
    assign left_only   = left_black && !right_black;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Mode next state
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_NORMAL: begin
                if (r_last_both_white) begin
                    n_mode = MODE_LEFT_WAIT;
                end else if (both_black) begin
                    n_mode = MODE_RIGHT;
                end
            end
            MODE_LEFT_WAIT: begin
                if (r_both_black_run >= r_crossing_run_len) begin
                    n_mode = MODE_LEFT_SPIN;
                end else if (r_left_black_run >= r_side_run_len) begin
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_LEFT_SPIN: begin
                if (!both_black) begin
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_RIGHT: begin
                if (r_both_black_run >= r_crossing_run_len) begin
                    n_mode = MODE_NORMAL;
                end
            end
            default: n_mode = MODE_NORMAL;
        endcase
    end

    // Motor directions from the current pattern and the new mode
    always_comb begin
        priority if (both_black) begin
            n_left_rev  = (n_mode == MODE_LEFT_SPIN);
            n_right_rev = (n_mode != MODE_LEFT_SPIN);
        end else if (left_only) begin
            n_left_rev  = 1'b0;
            n_right_rev = 1'b0;
        end else begin
            n_left_rev  = 1'b1;
            n_right_rev = 1'b0;
        end
    end

    always_comb begin
        n_both_black_run = '0;
        n_left_black_run = '0;
        if (both_black) begin
            n_both_black_run = (r_both_black_run == RUN_MAX) ? r_both_black_run
                                                             : r_both_black_run + 1'b1;
        end
        if (left_only) begin
            n_left_black_run = (r_left_black_run == RUN_MAX) ? r_left_black_run
                                                             : r_left_black_run + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black_threshold  <= BLACK_THRESHOLD_RST;
            r_crossing_run_len <= CROSSING_RUN_LEN_RST;
            r_side_run_len     <= SIDE_RUN_LEN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BLACK_THRESHOLD:  r_black_threshold  <= i_cfg_data;
                CFG_CROSSING_RUN_LEN: r_crossing_run_len <= i_cfg_data;
                CFG_SIDE_RUN_LEN:     r_side_run_len     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode            <= MODE_NORMAL;
            r_both_black_run  <= '0;
            r_left_black_run  <= '0;
            r_last_both_white <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (accept) begin
                r_mode            <= n_mode;
                r_both_black_run  <= n_both_black_run;
                r_left_black_run  <= n_left_black_run;
                r_last_both_white <= both_white;
                r_out_valid       <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left_rev  <= n_left_rev;
            r_right_rev <= n_right_rev;
            r_out_mode  <= n_mode;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_mode, r_right_rev, r_left_rev};

endmodule

// ===== sv/lfmc_checker.sv =====
// Port-level checker for the line follower mode controller, bound to the top level.
// Depends on lfmc_pkg and line_follower_mode_controller.
module lfmc_checker
    import lfmc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // A result beat held back by the sink keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Every accepted sample beat produces a result beat in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted sample produced no result");

    // The right motor never runs backward while the block spins left.
    a_spin_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[3:2] == MODE_LEFT_SPIN) |-> !m_axis_tdata[1])
        else $error("right motor reversed in left-spin mode");

endmodule

bind line_follower_mode_controller lfmc_checker u_lfmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
